// File: sv/cpus_pkg.sv
`default_nettype none
package cpus_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int STAMP_BITS  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 4;

    // Command codes.
    localparam logic [3:0] CMD_SCHEDULE   = 4'd0;
    localparam logic [3:0] CMD_CANCEL_ID  = 4'd1;
    localparam logic [3:0] CMD_CANCEL_KEY = 4'd2;
    localparam logic [3:0] CMD_CANCEL_ALL = 4'd3;
    localparam logic [3:0] CMD_TICK       = 4'd4;
    localparam logic [3:0] CMD_RUN        = 4'd5;
    localparam logic [3:0] CMD_BATCH      = 4'd6;
    localparam logic [3:0] CMD_FLUSH      = 4'd7;
    localparam logic [3:0] CMD_COUNT_PEND = 4'd8;
    localparam logic [3:0] CMD_COUNT_DUE  = 4'd9;

    // Result kinds.
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_TASK = 2'd1;
    localparam logic [1:0] KIND_SUM  = 2'd2;

    // Priority codes.
    localparam logic [1:0] PRIO_LOW = 2'd2;
    localparam logic [1:0] PRIO_ALL = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DEFERRED  = 2'd0;
    localparam logic [1:0] REG_DELAY     = 2'd1;
    localparam logic [1:0] REG_MAX_BATCH = 2'd2;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [1:0]            prio;
        logic [STAMP_BITS-1:0] stamp;
        logic [TIME_BITS-1:0]  due;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: sv/cpus_ram.sv
`default_nettype none
module cpus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/coalescing_priority_update_scheduler.sv
// Coalescing priority update scheduler. Requests enter on in_valid/in_ready one at a time and
// each defined command gives its results on out_valid/out_ready, the final one marked by last.
// Task payloads live in a single-port-read memory, so every walk reads the table one entry at a
// time. Schedule, cancel by id and cancel all answer without a walk; cancel by key and the two
// count queries walk the table once. Tick, run, flush and batch first coalesce, with one walk
// per live row, then walk once per dispatched task plus, unless a batch reaches its limit, one
// walk that finds nothing left. A stalled output holds the sequencer. Configuration registers
// sit at byte addresses 0, 4 and 8; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
`default_nettype none
module coalescing_priority_update_scheduler
    import cpus_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        command,
    input  wire logic [15:0]       key,
    input  wire logic [1:0]        priority_req,
    input  wire logic [5:0]        task_id,
    input  wire logic [31:0]       now_ms,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        kind,
    output logic      [15:0]       out_key,
    output logic      [5:0]        out_task_id,
    output logic      [6:0]        count,
    output logic                   full_error,
    output logic                   last
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_CO_RD  = 4'd2;
    localparam logic [3:0] S_CO_REF = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_PICKED = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_ACK    = 4'd7;

    localparam logic [2:0] M_COAL  = 3'd0;
    localparam logic [2:0] M_PICK  = 3'd1;
    localparam logic [2:0] M_CKEY  = 3'd2;
    localparam logic [2:0] M_CPEND = 3'd3;
    localparam logic [2:0] M_CDUE  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [3:0]             state_reg, state_next;
    logic [2:0]             mode_reg, mode_next;
    logic [3:0]             cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [1:0]             prio_reg, prio_next;
    logic [5:0]             id_reg, id_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   def_en_reg, def_en_next;
    logic [15:0]            delay_reg, delay_next;
    logic [6:0]             max_batch_reg, max_batch_next;
    logic [STAMP_BITS-1:0]  stamp_reg, stamp_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [IDX_W-1:0]       ci_reg, ci_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [KEY_BITS-1:0]    ref_key_reg, ref_key_next;
    logic [STAMP_BITS-1:0]  ref_age_reg, ref_age_next;
    logic                   kill_reg, kill_next;
    logic [CNT_W-1:0]       acc_reg, acc_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [1:0]             best_prio_reg, best_prio_next;
    logic [STAMP_BITS-1:0]  best_age_reg, best_age_next;
    logic [KEY_BITS-1:0]    best_key_reg, best_key_next;
    logic                   ov_reg, ov_next;
    logic [1:0]             kind_reg, kind_next;
    logic [15:0]            okey_reg, okey_next;
    logic [5:0]             oid_reg, oid_next;
    logic [6:0]             ocnt_reg, ocnt_next;
    logic                   ofull_reg, ofull_next;
    logic                   olast_reg, olast_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    entry_t                 ram_wdata, ram_rdata;

    logic                   emit_ok;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   jv;
    logic [STAMP_BITS-1:0]  age_j;
    logic [TIME_BITS-1:0]   time_sel;
    logic                   due_j;
    logic                   better;
    logic                   coal_hit;
    logic [6:0]             limit;
    logic                   cfg_wr;

    cpus_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEFERRED:  prdata = {31'd0, def_en_reg};
            REG_DELAY:     prdata = {16'd0, delay_reg};
            REG_MAX_BATCH: prdata = {25'd0, max_batch_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Handshake outputs.
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign out_key     = okey_reg;
    assign out_task_id = oid_reg;
    assign count       = ocnt_reg;
    assign full_error  = ofull_reg;
    assign last        = olast_reg;
    assign emit_ok     = !ov_reg || out_ready;

    // Lowest free slot for a new task.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Per-entry tests while walking the table.
    assign jv       = valid_reg[j_reg];
    assign age_j    = stamp_reg - ram_rdata.stamp;
    assign time_sel = (mode_reg == M_CDUE) ? now_reg : time_reg;
    assign due_j    = (cmd_reg == CMD_FLUSH) || !def_en_reg || (ram_rdata.due <= time_sel);
    assign better   = !best_found_reg
                      || ((cmd_reg != CMD_BATCH) && (ram_rdata.prio < best_prio_reg))
                      || (((cmd_reg == CMD_BATCH) || (ram_rdata.prio == best_prio_reg))
                          && (age_j > best_age_reg));
    assign coal_hit = jv && (j_reg != ci_reg) && (ram_rdata.key == ref_key_reg)
                      && (age_j < ref_age_reg);
    assign limit    = (max_batch_reg == 7'd0) ? 7'd1 : max_batch_reg;

    // Read address: the coalescing row or the walk position.
    always_comb
    begin
        if (state_reg == S_CO_RD)
        begin
            ram_raddr = ci_reg;
        end
        else if (cnt_reg == CNT_END)
        begin
            ram_raddr = '0;
        end
        else
        begin
            ram_raddr = cnt_reg[IDX_W-1:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        prio_next       = prio_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        def_en_next     = def_en_reg;
        delay_next      = delay_reg;
        max_batch_next  = max_batch_reg;
        stamp_next      = stamp_reg;
        time_next       = time_reg;
        ci_next         = ci_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        ref_key_next    = ref_key_reg;
        ref_age_next    = ref_age_reg;
        kill_next       = kill_reg;
        acc_next        = acc_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_age_next   = best_age_reg;
        best_key_next   = best_key_reg;
        ov_next         = ov_reg && !out_ready;
        kind_next       = kind_reg;
        okey_next       = okey_reg;
        oid_next        = oid_reg;
        ocnt_next       = ocnt_reg;
        ofull_next      = ofull_reg;
        olast_next      = olast_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_idx;
        ram_wdata.key   = key_reg;
        ram_wdata.prio  = (prio_reg == PRIO_ALL) ? PRIO_LOW : prio_reg;
        ram_wdata.stamp = stamp_reg;
        ram_wdata.due   = def_en_reg ? (time_reg + TIME_BITS'(delay_reg)) : '0;

        // Configuration writes.
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DEFERRED:  def_en_next    = pwdata[0];
                REG_DELAY:     delay_next     = pwdata[15:0];
                REG_MAX_BATCH: max_batch_next = pwdata[6:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    key_next   = KEY_BITS'(key);
                    prio_next  = priority_req;
                    id_next    = task_id;
                    now_next   = TIME_BITS'(now_ms);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (cmd_reg) inside
                    CMD_SCHEDULE:
                    begin
                        if (emit_ok)
                        begin
                            ov_next    = 1'b1;
                            kind_next  = KIND_ACK;
                            okey_next  = '0;
                            ocnt_next  = '0;
                            olast_next = 1'b1;
                            ofull_next = !free_found;
                            oid_next   = free_found ? 6'(free_idx) : 6'd0;
                            if (free_found)
                            begin
                                ram_we               = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                stamp_next           = stamp_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CANCEL_ID:
                    begin
                        if (emit_ok)
                        begin
                            if (id_reg < 6'(TABLE_DEPTH))
                            begin
                                valid_next[id_reg[IDX_W-1:0]] = 1'b0;
                            end
                            ov_next    = 1'b1;
                            kind_next  = KIND_ACK;
                            okey_next  = '0;
                            oid_next   = id_reg;
                            ocnt_next  = '0;
                            ofull_next = 1'b0;
                            olast_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CANCEL_KEY:
                    begin
                        mode_next  = M_CKEY;
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                    CMD_CANCEL_ALL:
                    begin
                        if (emit_ok)
                        begin
                            valid_next = '0;
                            ov_next    = 1'b1;
                            kind_next  = KIND_ACK;
                            okey_next  = '0;
                            oid_next   = '0;
                            ocnt_next  = '0;
                            ofull_next = 1'b0;
                            olast_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_TICK, CMD_RUN, CMD_BATCH, CMD_FLUSH:
                    begin
                        if (cmd_reg == CMD_TICK)
                        begin
                            time_next = now_reg;
                        end
                        acc_next   = '0;
                        ci_next    = '0;
                        state_next = S_CO_RD;
                    end
                    CMD_COUNT_PEND, CMD_COUNT_DUE:
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        mode_next  = (cmd_reg == CMD_COUNT_PEND) ? M_CPEND : M_CDUE;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Coalescing: load one live row, then compare it against the table.
            S_CO_RD:
            begin
                if (valid_reg[ci_reg])
                begin
                    state_next = S_CO_REF;
                end
                else if (ci_reg == IDX_LAST)
                begin
                    mode_next       = M_PICK;
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                end
            end

            S_CO_REF:
            begin
                ref_key_next = ram_rdata.key;
                ref_age_next = stamp_reg - ram_rdata.stamp;
                kill_next    = 1'b0;
                cnt_next     = '0;
                mode_next    = M_COAL;
                state_next   = S_SCAN;
            end

            // Table walk: the read issued last cycle is examined now.
            S_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    j_next   = cnt_reg[IDX_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    case (mode_reg)
                        M_COAL:
                        begin
                            kill_next = kill_reg || coal_hit;
                        end
                        M_PICK:
                        begin
                            if (jv && due_j && better)
                            begin
                                best_found_next = 1'b1;
                                best_idx_next   = j_reg;
                                best_prio_next  = ram_rdata.prio;
                                best_age_next   = age_j;
                                best_key_next   = ram_rdata.key;
                            end
                        end
                        M_CKEY:
                        begin
                            if (jv && (ram_rdata.key == key_reg))
                            begin
                                valid_next[j_reg] = 1'b0;
                            end
                        end
                        M_CPEND:
                        begin
                            if (jv && ((prio_reg == PRIO_ALL) || (ram_rdata.prio == prio_reg)))
                            begin
                                acc_next = acc_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (jv && due_j)
                            begin
                                acc_next = acc_reg + 1'b1;
                            end
                        end
                    endcase

                    // Walk finished: act on what it found.
                    if (cnt_reg == CNT_END)
                    begin
                        case (mode_reg)
                            M_COAL:
                            begin
                                if (kill_reg || coal_hit)
                                begin
                                    valid_next[ci_reg] = 1'b0;
                                end
                                if (ci_reg == IDX_LAST)
                                begin
                                    mode_next       = M_PICK;
                                    cnt_next        = '0;
                                    best_found_next = 1'b0;
                                end
                                else
                                begin
                                    ci_next    = ci_reg + 1'b1;
                                    state_next = S_CO_RD;
                                end
                            end
                            M_PICK:  state_next = S_PICKED;
                            M_CKEY:  state_next = S_ACK;
                            default: state_next = S_SUM;
                        endcase
                    end
                end
            end

            // Dispatch the chosen task, then look for the next one.
            S_PICKED:
            begin
                if (!best_found_reg)
                begin
                    state_next = S_SUM;
                end
                else if (emit_ok)
                begin
                    ov_next                   = 1'b1;
                    kind_next                 = KIND_TASK;
                    okey_next                 = 16'(best_key_reg);
                    oid_next                  = 6'(best_idx_reg);
                    ocnt_next                 = '0;
                    ofull_next                = 1'b0;
                    olast_next                = 1'b0;
                    valid_next[best_idx_reg]  = 1'b0;
                    acc_next                  = acc_reg + 1'b1;
                    if ((cmd_reg == CMD_BATCH) && ((7'(acc_reg) + 7'd1) >= limit))
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        mode_next       = M_PICK;
                        cnt_next        = '0;
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SUM:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_SUM;
                    okey_next  = '0;
                    oid_next   = '0;
                    ocnt_next  = 7'(acc_reg);
                    ofull_next = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ACK:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_ACK;
                    okey_next  = '0;
                    oid_next   = '0;
                    ocnt_next  = '0;
                    ofull_next = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            def_en_reg    <= 1'b1;
            delay_reg     <= 16'd16;
            max_batch_reg <= 7'd16;
            stamp_reg     <= '0;
            time_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            def_en_reg    <= def_en_next;
            delay_reg     <= delay_next;
            max_batch_reg <= max_batch_next;
            stamp_reg     <= stamp_next;
            time_reg      <= time_next;
            ov_reg        <= ov_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        prio_reg       <= prio_next;
        id_reg         <= id_next;
        now_reg        <= now_next;
        ci_reg         <= ci_next;
        cnt_reg        <= cnt_next;
        j_reg          <= j_next;
        ref_key_reg    <= ref_key_next;
        ref_age_reg    <= ref_age_next;
        kill_reg       <= kill_next;
        acc_reg        <= acc_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_age_reg   <= best_age_next;
        best_key_reg   <= best_key_next;
        kind_reg       <= kind_next;
        okey_reg       <= okey_next;
        oid_reg        <= oid_next;
        ocnt_reg       <= ocnt_next;
        ofull_reg      <= ofull_next;
        olast_reg      <= olast_next;
    end

endmodule
`default_nettype wire

// File: sv/cpus_checker.sv
`default_nettype none
module cpus_checker
    import cpus_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [3:0]        command,
    input wire logic [15:0]       key,
    input wire logic [1:0]        priority_req,
    input wire logic [5:0]        task_id,
    input wire logic [31:0]       now_ms,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        kind,
    input wire logic [15:0]       out_key,
    input wire logic [5:0]        out_task_id,
    input wire logic [6:0]        count,
    input wire logic              full_error,
    input wire logic              last
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_task_id)
            && $stable(count) && $stable(last))
        else $error("stalled result changed");

    // A full error is always a final acknowledge.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_error |-> kind == KIND_ACK && last && out_task_id == 6'd0)
        else $error("full error on a wrong result");

    // A dispatched task is never the final result and carries no count.
    a_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TASK |-> !last && count == 7'd0)
        else $error("dispatched task result malformed");

    // One request at a time: the block is busy right after it takes one.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

endmodule

bind coalescing_priority_update_scheduler cpus_checker u_cpus_checker (.*);
`default_nettype wire

// File: tb/coalescing_priority_update_scheduler_tb.sv
`default_nettype none
module coalescing_priority_update_scheduler_tb;
    import cpus_pkg::*;

    // Shape of one request and one result.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] key;
        logic [1:0]  prio;
        logic [5:0]  id;
        logic [31:0] now;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [5:0]  id;
        logic [6:0]  cnt;
        logic        full;
        logic        last;
    } result_t;

    // Stimulus table row; has_expect marks rows whose single result is typed in.
    typedef struct packed {
        request_t req;
        logic     has_expect;
        result_t  res;
    } row_t;

    localparam logic [3:0] CMD_BAD = 4'd12;
    localparam logic [1:0] PRIO_HIGH = 2'd0;
    localparam logic [1:0] PRIO_NORMAL = 2'd1;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic [3:0] command;
    logic [15:0] key;
    logic [1:0] priority_req;
    logic [5:0] task_id;
    logic [31:0] now_ms;
    logic out_valid;
    logic out_ready;
    logic [1:0] kind;
    logic [15:0] out_key;
    logic [5:0] out_task_id;
    logic [6:0] count;
    logic full_error;
    logic last;

    coalescing_priority_update_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key(key), .priority_req(priority_req),
        .task_id(task_id), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_key(out_key), .out_task_id(out_task_id),
        .count(count), .full_error(full_error), .last(last)
    );

    // Shadow of the scheduler's table and registers.
    logic        sh_deferred;
    logic [15:0] sh_delay;
    logic [6:0]  sh_max_batch;
    logic        sh_valid [TABLE_DEPTH];
    logic [15:0] sh_key [TABLE_DEPTH];
    logic [1:0]  sh_prio [TABLE_DEPTH];
    logic [31:0] sh_stamp [TABLE_DEPTH];
    logic [31:0] sh_due [TABLE_DEPTH];
    logic [31:0] sh_next_stamp;
    logic [31:0] sh_time;

    result_t pending_results[$];
    int errors;
    int stall_pct;
    int idle_pct;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] task_age(int i);
        return sh_next_stamp - sh_stamp[i];
    endfunction

    function automatic result_t make_result(logic [1:0] k, logic [15:0] kk, logic [5:0] id,
                                            logic [6:0] c, logic f, logic l);
        result_t r;
        r.kind = k;
        r.key = kk;
        r.id = id;
        r.cnt = c;
        r.full = f;
        r.last = l;
        return r;
    endfunction

    // Append one expected result at the tail of the queue.
    task automatic add_expected(result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Keep only the newest task for each key.
    task automatic merge_duplicate_keys();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sh_valid[i])
            begin
                for (int j = 0; j < TABLE_DEPTH; j++)
                begin
                    if (j != i && sh_valid[j] && sh_key[j] == sh_key[i]
                        && task_age(j) < task_age(i))
                    begin
                        sh_valid[i] = 1'b0;
                        break;
                    end
                end
            end
        end
    endtask

    // Oldest due task of a priority, any priority when prio is PRIO_ALL; -1 if none.
    function automatic int oldest_due_slot(logic [1:0] prio, logic force_all);
        int best;
        best = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sh_valid[i] && (prio == PRIO_ALL || sh_prio[i] == prio)
                && (force_all || !sh_deferred || sh_due[i] <= sh_time))
            begin
                if (best < 0 || task_age(i) > task_age(best))
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic dispatch_slot(int s);
        add_expected(make_result(KIND_TASK, sh_key[s], 6'(s), 7'd0, 1'b0, 1'b0));
        sh_valid[s] = 1'b0;
    endtask

    // Work out the results of one accepted request and update the shadow table.
    task automatic predict_request(request_t r);
        int s;
        int n;
        int limit;
        logic [1:0] p;
        n = 0;
        case (r.cmd)
            CMD_SCHEDULE:
            begin
                s = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!sh_valid[i])
                    begin
                        s = i;
                        break;
                    end
                end
                if (s < 0)
                    add_expected(make_result(KIND_ACK, 0, 0, 0, 1'b1, 1'b1));
                else
                begin
                    sh_valid[s] = 1'b1;
                    sh_key[s] = r.key;
                    sh_prio[s] = (r.prio == PRIO_ALL) ? PRIO_LOW : r.prio;
                    sh_stamp[s] = sh_next_stamp;
                    sh_due[s] = sh_deferred ? sh_time + 32'(sh_delay) : 32'd0;
                    sh_next_stamp = sh_next_stamp + 1;
                    add_expected(make_result(KIND_ACK, 0, 6'(s), 0, 1'b0, 1'b1));
                end
            end
            CMD_CANCEL_ID:
            begin
                if (r.id < TABLE_DEPTH)
                    sh_valid[r.id] = 1'b0;
                add_expected(make_result(KIND_ACK, 0, r.id, 0, 1'b0, 1'b1));
            end
            CMD_CANCEL_KEY, CMD_CANCEL_ALL:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (r.cmd == CMD_CANCEL_ALL || sh_key[i] == r.key)
                        sh_valid[i] = 1'b0;
                end
                add_expected(make_result(KIND_ACK, 0, 0, 0, 1'b0, 1'b1));
            end
            CMD_TICK, CMD_RUN, CMD_FLUSH:
            begin
                if (r.cmd == CMD_TICK)
                    sh_time = r.now;
                merge_duplicate_keys();
                for (int pi = 0; pi < 3; pi++)
                begin
                    p = 2'(pi);
                    s = oldest_due_slot(p, r.cmd == CMD_FLUSH);
                    while (s >= 0)
                    begin
                        dispatch_slot(s);
                        n++;
                        s = oldest_due_slot(p, r.cmd == CMD_FLUSH);
                    end
                end
                add_expected(make_result(KIND_SUM, 0, 0, 7'(n), 1'b0, 1'b1));
            end
            CMD_BATCH:
            begin
                limit = (sh_max_batch == 0) ? 1 : int'(sh_max_batch);
                merge_duplicate_keys();
                while (n < limit)
                begin
                    s = oldest_due_slot(PRIO_ALL, 1'b0);
                    if (s < 0)
                        break;
                    dispatch_slot(s);
                    n++;
                end
                add_expected(make_result(KIND_SUM, 0, 0, 7'(n), 1'b0, 1'b1));
            end
            CMD_COUNT_PEND, CMD_COUNT_DUE:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (sh_valid[i] && (r.cmd == CMD_COUNT_PEND
                        ? (r.prio == PRIO_ALL || sh_prio[i] == r.prio)
                        : (!sh_deferred || sh_due[i] <= r.now)))
                        n++;
                end
                add_expected(make_result(KIND_SUM, 0, 0, 7'(n), 1'b0, 1'b1));
            end
            default:
            begin
                // Undefined commands are dropped without a result.
            end
        endcase
    endtask

    // Output side: random stall and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no expectation: kind %0d id %0d", kind, out_task_id);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errors++;
                    end
                    if (out_key !== want.key)
                    begin
                        $error("out_key: expected %0d, got %0d", want.key, out_key);
                        errors++;
                    end
                    if (out_task_id !== want.id)
                    begin
                        $error("out_task_id: expected %0d, got %0d", want.id, out_task_id);
                        errors++;
                    end
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0d, got %0d", want.cnt, count);
                        errors++;
                    end
                    if (full_error !== want.full)
                    begin
                        $error("full_error: expected %0d, got %0d", want.full, full_error);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
        else
        begin
            out_ready <= 1'b0;
        end
    end

    // Register write over the configuration port, setup then access.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEFERRED: sh_deferred = value[0];
            REG_DELAY: sh_delay = value[15:0];
            default: sh_max_batch = value[6:0];
        endcase
        @(posedge clk);
    endtask

    // Valid stays up after a request is taken; it drops only when the sender goes idle.
    task automatic send_request(request_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= r.cmd;
        key <= r.key;
        priority_req <= r.prio;
        task_id <= r.id;
        now_ms <= r.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(r);
    endtask

    // Wait until every expected result has arrived and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    function automatic request_t make_request(logic [3:0] c, logic [15:0] k, logic [1:0] p,
                                              logic [5:0] id, logic [31:0] t);
        request_t r;
        r.cmd = c;
        r.key = k;
        r.prio = p;
        r.id = id;
        r.now = t;
        return r;
    endfunction

    // Mostly small key sets so that coalescing and cancel by key find matches.
    function automatic request_t random_request(logic [31:0] base_time);
        int pick;
        logic [15:0] k;
        logic [3:0] c;
        pick = $urandom_range(99);
        k = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
        if (pick < 45) c = CMD_SCHEDULE;
        else if (pick < 50) c = CMD_CANCEL_ID;
        else if (pick < 55) c = CMD_CANCEL_KEY;
        else if (pick < 57) c = CMD_CANCEL_ALL;
        else if (pick < 70) c = CMD_TICK;
        else if (pick < 75) c = CMD_RUN;
        else if (pick < 83) c = CMD_BATCH;
        else if (pick < 86) c = CMD_FLUSH;
        else if (pick < 91) c = CMD_COUNT_PEND;
        else if (pick < 96) c = CMD_COUNT_DUE;
        else c = 4'($urandom_range(10, 15));
        return make_request(c, k, 2'($urandom), 6'($urandom),
                            ($urandom_range(9) == 0) ? $urandom
                                                     : base_time + $urandom_range(40));
    endfunction

    row_t directed_rows[$];
    logic [31:0] clock_ms;

    initial
    begin
        row_t row;
        request_t r;
        logic [31:0] cfg_delay [4];
        logic [31:0] cfg_batch [4];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_SCHEDULE;
        key = '0;
        priority_req = '0;
        task_id = '0;
        now_ms = '0;
        errors = 0;
        stall_pct = 0;
        idle_pct = 0;
        sh_deferred = 1'b1;
        sh_delay = 16'd16;
        sh_max_batch = 7'd16;
        sh_next_stamp = '0;
        sh_time = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_key[i] = '0;
            sh_prio[i] = '0;
            sh_stamp[i] = '0;
            sh_due[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: known answers after reset, extremes and the full table.
        row.has_expect = 1'b1;
        row.req = make_request(CMD_COUNT_PEND, 0, PRIO_ALL, 0, 0);
        row.res = make_result(KIND_SUM, 0, 0, 0, 1'b0, 1'b1);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_TICK, 16'hFFFF, PRIO_HIGH, 6'h3F, 32'hFFFF_FFFF);
        row.res = make_result(KIND_SUM, 0, 0, 0, 1'b0, 1'b1);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_CANCEL_ID, 0, 0, 6'd63, 0);
        row.res = make_result(KIND_ACK, 0, 6'd63, 0, 1'b0, 1'b1);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_BAD, 16'hFFFF, PRIO_ALL, 6'h3F, 32'hFFFF_FFFF);
        row.has_expect = 1'b0;
        directed_rows.insert(directed_rows.size(), row);
        for (int i = 0; i < 17; i++)
        begin
            row.req = make_request(CMD_SCHEDULE, (i % 2) ? 16'hFFFF : 16'(i), 2'(i % 4),
                                   6'(i), 32'h5555_AAAA);
            row.has_expect = 1'b1;
            row.res = (i < 16) ? make_result(KIND_ACK, 0, 6'(i), 0, 1'b0, 1'b1)
                               : make_result(KIND_ACK, 0, 0, 0, 1'b1, 1'b1);
            directed_rows.insert(directed_rows.size(), row);
        end
        row.has_expect = 1'b0;
        row.req = make_request(CMD_COUNT_DUE, 0, 0, 0, 32'hFFFF_FFFF);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_BATCH, 0, 0, 0, 0);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_CANCEL_KEY, 16'd2, 0, 0, 0);
        directed_rows.insert(directed_rows.size(), row);
        row.req = make_request(CMD_FLUSH, 0, 0, 0, 0);
        directed_rows.insert(directed_rows.size(), row);
        foreach (directed_rows[n])
        begin
            send_request(directed_rows[n].req);
            if (directed_rows[n].has_expect)
            begin
                // The typed-in answer must agree with the predicted one.
                if (pending_results[$] !== directed_rows[n].res)
                begin
                    $error("row %0d: expected %h, predicted %h", n,
                           directed_rows[n].res, pending_results[$]);
                    errors++;
                end
            end
        end
        drain();

        // Random phases across register settings, extremes included.
        cfg_delay = '{32'd0, 32'd65535, 32'd5, 32'd16};
        cfg_batch = '{32'd0, 32'd64, 32'd1, 32'd3};
        clock_ms = 32'd100;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_register(REG_DEFERRED, (ph == 2) ? 32'd0 : 32'hFFFF_FFFF);
            write_register(REG_DELAY, cfg_delay[ph] | (ph == 1 ? 32'hFFFF_0000 : 0));
            write_register(REG_MAX_BATCH, cfg_batch[ph]);
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 73; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 73; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < 87; n++)
            begin
                r = random_request(clock_ms);
                if (r.cmd == CMD_TICK)
                    clock_ms = r.now;
                send_request(r);
                if (n == 40)
                begin
                    // Hold off new requests until the block has answered everything.
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit well beyond the slowest legal run.
    initial
    begin
        #200000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire

// File: coalescing_priority_update_scheduler.f
sv/cpus_pkg.sv
sv/cpus_ram.sv
sv/coalescing_priority_update_scheduler.sv
sv/cpus_checker.sv
tb/coalescing_priority_update_scheduler_tb.sv
